>>> hw/rtl/rlm_pkg.sv
// Shared types, constants and register codes for the RMS level meter.
`timescale 1ns / 1ps
package rlm_pkg;

  // Fixed widths of the data path
  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = 16;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 39;
  localparam int CNT_W     = 13;
  localparam int LVL_W     = 32;
  localparam int Q16_W     = 16;
  localparam int SHIFT_W   = 5;

  // Divider: 48-bit dividend over a 32-bit divisor
  localparam int DVD_W     = 48;
  localparam int DSR_W     = 32;

  // Square root: 30-bit mean shifted up to a 64-bit radicand
  localparam int MEAN_W    = 30;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = 32;

  localparam int BUFFER_FRAMES = 256;

  // Stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE        = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH_WEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DECAY_SHIFT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_LEVEL = 2'd3;

  localparam logic              RST_ENABLE        = 1'b1;
  localparam logic [Q16_W-1:0]  RST_SMOOTH_WEIGHT = 16'd13107;
  localparam logic [SHIFT_W-1:0] RST_DECAY_SHIFT  = 5'd23;
  localparam logic [Q16_W-1:0]  RST_TRIGGER_LEVEL = 16'd6554;

  // Word kinds carried on tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic               enable;
    logic [Q16_W-1:0]   smooth_weight;
    logic [SHIFT_W-1:0] decay_shift;
    logic [Q16_W-1:0]   trigger_level;
  } cfg_t;

  // One classified word waiting for the back end
  typedef struct packed {
    logic             is_tick;
    logic [MAG_W-1:0] mag;
    logic             last;
    logic             touched;
  } q_entry_t;

endpackage

>>> hw/rtl/rlm_front.sv
// Front end: accepts input words, forms sample magnitude, queues them.
`timescale 1ns / 1ps
module rlm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rlm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  input  logic                             enable,
  output logic                             q_valid,
  output rlm_pkg::q_entry_t                q_entry,
  input  logic                             q_pop
);
  import rlm_pkg::*;

  q_entry_t    buf_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [SAMPLE_W-1:0] smp;
  logic [MAG_W-1:0]    mag;
  logic                accept;
  logic                push;
  logic                pop;
  q_entry_t            entry;

  assign in_tready = (cnt_r != 2'd2);
  assign accept    = in_tvalid && in_tready;

  assign smp = in_tdata[SAMPLE_W-1:0];
  assign mag = smp[SAMPLE_W-1] ? MAG_W'(~smp + 16'd1) : smp;

  always_comb begin
    entry.is_tick = (in_tuser == OP_TICK);
    entry.mag     = mag;
    entry.last    = in_tlast;
    entry.touched = in_tdata[SAMPLE_W];
  end

  // samples are dropped while audio is off
  assign push = accept && (entry.is_tick || enable);
  assign pop  = q_pop && q_valid;

  assign q_valid = (cnt_r != 2'd0);
  assign q_entry = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= entry;
    end
  end

endmodule

>>> hw/rtl/rlm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rlm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rlm_pkg::DVD_W-1:0]    dividend,
  input  logic [rlm_pkg::DSR_W-1:0]    divisor,
  output logic                         done,
  output logic [rlm_pkg::DVD_W-1:0]    quotient
);
  import rlm_pkg::*;

  localparam int CNT_BITS = $clog2(DVD_W);

  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [DSR_W-1:0]    rem_r, rem_nxt;
  logic [DSR_W-1:0]    dsr_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [DSR_W:0] rem_sh;
  logic [DSR_W:0] rem_sub;
  logic           ge;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dsr_r});
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    rem_nxt = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> hw/rtl/rlm_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module rlm_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rlm_pkg::MEAN_W-1:0]   mean,
  output logic                         done,
  output logic [rlm_pkg::ROOT_W-1:0]   root
);
  import rlm_pkg::*;

  localparam int REM_W    = ROOT_W + 2;
  localparam int CNT_BITS = $clog2(ROOT_W);

  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_comb begin
    rem_nxt  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // radicand is the mean in Q0.30 moved up to Q0.64 scale
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {mean, (RAD_W - MEAN_W)'(0)};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> hw/rtl/rlm_back.sv
// Back end: accumulation, RMS, smoothing, peak tracking and tick reports.
`timescale 1ns / 1ps
module rlm_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rlm_pkg::cfg_t                     cfg,
  input  logic                              q_valid,
  input  rlm_pkg::q_entry_t                 q_entry,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rlm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import rlm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_SQ   = 10'b00_0000_0010,
    S_ACC  = 10'b00_0000_0100,
    S_MEAN = 10'b00_0000_1000,
    S_ROOT = 10'b00_0001_0000,
    S_MUL  = 10'b00_0010_0000,
    S_MIX  = 10'b00_0100_0000,
    S_PEAK = 10'b00_1000_0000,
    S_LVL  = 10'b01_0000_0000,
    S_TICK = 10'b10_0000_0000
  } state_t;

  localparam int MIX_W = LVL_W + Q16_W + 1;

  state_t   state_r, state_nxt;
  q_entry_t item_r;

  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LVL_W-1:0]  smoothed_r;
  logic [LVL_W-1:0]  peak_r;
  logic [SQ_W-1:0]   sq_r;
  logic [ROOT_W-1:0] rms_r;
  logic [MIX_W-1:0]  p1_r;
  logic [MIX_W-1:0]  p2_r;
  logic [Q16_W-1:0]  level_r;

  logic              out_valid_r;
  logic [Q16_W-1:0]  out_level_r;
  logic              out_trig_r;
  logic [Q16_W-1:0]  out_smooth_r;

  // accumulate step
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              finish;

  // mixing
  logic [Q16_W:0]    inv_w;
  logic [MIX_W-1:0]  mix;

  logic              out_free;
  logic              live_tick;

  // divider, shared by mean and level, and square root
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DSR_W-1:0]  div_dsr;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  rlm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  rlm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .mean  (div_q[MEAN_W-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);
  assign sum_nxt = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign cnt_nxt = (cnt_r != {CNT_W{1'b1}}) ? cnt_r + 1'b1 : cnt_r;
  assign finish  = item_r.last || (cnt_nxt >= CNT_W'(BUFFER_FRAMES));

  assign inv_w = 17'h1_0000 - {1'b0, cfg.smooth_weight};
  assign mix   = p1_r + p2_r;

  assign out_free  = !out_valid_r || out_tready;
  assign live_tick = cfg.enable && !item_r.touched;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    div_dvd    = {smoothed_r, Q16_W'(0)};
    div_dsr    = peak_r;
    sqrt_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (!q_entry.is_tick) begin
            state_nxt = S_SQ;
          end else if (peak_r == '0) begin
            state_nxt = S_TICK;
          end else begin
            div_start = 1'b1;
            state_nxt = S_LVL;
          end
        end
      end
      S_SQ: state_nxt = S_ACC;
      S_ACC: begin
        if (finish) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(sum_nxt);
          div_dsr   = DSR_W'(cnt_nxt);
          state_nxt = S_MEAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MEAN: begin
        if (div_done) begin
          if (div_q[DVD_W-1:MEAN_W] != '0) begin
            state_nxt = S_MUL;
          end else begin
            sqrt_start = 1'b1;
            state_nxt  = S_ROOT;
          end
        end
      end
      S_ROOT: if (sqrt_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_MIX;
      S_MIX:  state_nxt = S_PEAK;
      S_PEAK: state_nxt = S_IDLE;
      S_LVL:  if (div_done) state_nxt = S_TICK;
      S_TICK: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      smoothed_r  <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_TICK && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_ACC: begin
          if (finish) begin
            sum_r <= '0;
            cnt_r <= '0;
          end else begin
            sum_r <= sum_nxt;
            cnt_r <= cnt_nxt;
          end
        end
        S_MIX: smoothed_r <= mix[LVL_W+Q16_W-1:Q16_W];
        S_PEAK: begin
          if (smoothed_r > peak_r) peak_r <= smoothed_r;
        end
        S_TICK: begin
          if (out_free && live_tick) peak_r <= peak_r - (peak_r >> cfg.decay_shift);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_entry;
    if (state_r == S_IDLE) level_r <= '0;
    if (state_r == S_SQ) sq_r <= item_r.mag * item_r.mag;
    if (state_r == S_MEAN && div_done) rms_r <= {ROOT_W{1'b1}};
    if (state_r == S_ROOT && sqrt_done) rms_r <= sqrt_root;
    if (state_r == S_MUL) begin
      p1_r <= MIX_W'(smoothed_r) * MIX_W'(inv_w);
      p2_r <= MIX_W'(rms_r) * MIX_W'(cfg.smooth_weight);
    end
    if (state_r == S_LVL && div_done) begin
      level_r <= (div_q[DVD_W-1:Q16_W] != '0) ? {Q16_W{1'b1}} : div_q[Q16_W-1:0];
    end
    if (state_r == S_TICK && out_free) begin
      out_level_r  <= level_r;
      out_trig_r   <= live_tick && (level_r > cfg.trigger_level);
      out_smooth_r <= smoothed_r[LVL_W-1 -: Q16_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_smooth_r, out_trig_r, out_level_r};

`ifndef SYNTH
  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_MEAN || state_r == S_LVL))
    else $error("divider finished outside a wait state");

  a_sqrt_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (state_r == S_ROOT))
    else $error("square root finished outside its wait state");

  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_TICK))
    else $error("result word raised without a tick");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r < CNT_W'(BUFFER_FRAMES)))
    else $error("buffer count passed the buffer size");
`endif

endmodule

>>> hw/rtl/rms_level_meter_core.sv
// Top level of the RMS level meter: configuration registers, front and back ends.
`timescale 1ns / 1ps
//
// Channel  Dir  Handshake             Contents
// in_      in   in_tvalid/in_tready   tdata: sample[15:0] touched[16]; tuser: op;
//                                     tlast: last_of_buffer
// out_     out  out_tvalid/out_tready tdata: level[15:0] trigger[16] smoothed_out[32:17]
// cfg_     in   cfg_valid/cfg_ready   cfg_addr: register index, cfg_wdata: value
//
// A sample word is squared and accumulated in the back end; the word that closes a
// buffer also runs the divider for the mean, the square root (skipped on saturation),
// mix and peak. A tick with nonzero peak uses the same divider (level = smoothed/peak).
// Reset is synchronous, active low: registers return to their defaults, sums, count,
// smoothed level and peak clear to zero.
// A two-word queue sits between the ends and the result sits in an output register,
// so the input keeps flowing while a result waits, until both queue words are taken.
module rms_level_meter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rlm_pkg::IN_TDATA_W-1:0]    in_tdata,   // sample[15:0], touched[16], pad
  input  logic                              in_tuser,   // op
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rlm_pkg::OUT_TDATA_W-1:0]   out_tdata,  // level[15:0], trigger[16],
                                                        // smoothed_out[32:17], pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rlm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rlm_pkg::*;

  cfg_t     cfg_r;
  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= RST_ENABLE;
      cfg_r.smooth_weight <= RST_SMOOTH_WEIGHT;
      cfg_r.decay_shift   <= RST_DECAY_SHIFT;
      cfg_r.trigger_level <= RST_TRIGGER_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_ENABLE:        cfg_r.enable        <= cfg_wdata[0];
        REG_SMOOTH_WEIGHT: cfg_r.smooth_weight <= cfg_wdata;
        REG_DECAY_SHIFT:   cfg_r.decay_shift   <= cfg_wdata[SHIFT_W-1:0];
        REG_TRIGGER_LEVEL: cfg_r.trigger_level <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: accept, classify, drop samples while audio is off
  rlm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .enable    (cfg_r.enable),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  // back: arithmetic sequencer and result register
  rlm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/sv/tb_rms_level_meter_core.sv
// Self-checking testbench for the RMS level meter core: directed and random stream traffic, checked per report.
`timescale 1ns / 1ps

module tb_rms_level_meter_core;
  import rlm_pkg::*;

  // Run bounds
  localparam int LIMIT_CYCLES = 5_000_000;  // hard stop, far above the slowest legal run
  localparam int DRAIN_CYCLES = 400;        // back end may still be closing buffers
  localparam int SETTLE_LIMIT = 20_000;     // wait for due reports before giving up
  localparam int SHOW_MAX     = 10;         // mismatches printed in full

  // One report word as the block sends it
  typedef struct packed {
    logic [Q16_W-1:0] level;
    logic             trigger;
    logic [Q16_W-1:0] smooth_hi;
  } report_t;

  // Tracks the meter's registers and state word by word and queues the reports due.
  class meter_tracker;
    logic               en;
    logic [Q16_W-1:0]   weight;
    logic [SHIFT_W-1:0] shift;
    logic [Q16_W-1:0]   thresh;
    logic [SUM_W-1:0]   sq_sum;
    logic [CNT_W-1:0]   n_held;
    logic [LVL_W-1:0]   smooth;
    logic [LVL_W-1:0]   peak;
    report_t            due_reports[$];
    int                 faults;
    int                 shown;

    function new();
      en     = RST_ENABLE;
      weight = RST_SMOOTH_WEIGHT;
      shift  = RST_DECAY_SHIFT;
      thresh = RST_TRIGGER_LEVEL;
      sq_sum = '0;
      n_held = '0;
      smooth = '0;
      peak   = '0;
      faults = 0;
      shown  = 0;
    endfunction

    function void flag(string msg);
      if (shown < SHOW_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
      shown++;
      faults++;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ENABLE:        en     = val[0];
        REG_SMOOTH_WEIGHT: weight = val;
        REG_DECAY_SHIFT:   shift  = val[SHIFT_W-1:0];
        REG_TRIGGER_LEVEL: thresh = val;
        default: ;
      endcase
    endfunction

    // floor(sqrt(v)), digit by digit
    function logic [ROOT_W-1:0] int_root(logic [RAD_W-1:0] v);
      logic [RAD_W-1:0] rem;
      logic [RAD_W-1:0] res;
      logic [RAD_W-1:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res[ROOT_W-1:0];
    endfunction

    // Mean square -> Q0.32 RMS -> smoothing -> peak hold
    function void close_buffer();
      logic [SUM_W-1:0]  mean;
      logic [ROOT_W-1:0] rms;
      logic [16:0]       keep;
      logic [63:0]       mix;
      mean = sq_sum / SUM_W'(n_held);
      if (mean[SUM_W-1:MEAN_W] != '0) rms = '1;   // mean of 1.0 saturates
      else rms = int_root({mean[MEAN_W-1:0], 34'b0});
      keep = 17'h1_0000 - {1'b0, weight};
      mix  = 64'(smooth) * 64'(keep) + 64'(rms) * 64'(weight);
      smooth = mix[47:16];
      if (smooth > peak) peak = smooth;
      sq_sum = '0;
      n_held = '0;
    endfunction

    function void take_word(logic op, logic [SAMPLE_W-1:0] smp, logic lst, logic tch);
      logic [MAG_W-1:0] mag;
      logic [SUM_W:0]   acc;
      logic [47:0]      quot;
      report_t          rep;
      if (op == OP_SAMPLE) begin
        if (!en) return;                          // ignored, partial buffer kept
        mag = smp[SAMPLE_W-1] ? (~smp + 16'd1) : smp;
        acc = {1'b0, sq_sum} + 40'(mag) * 40'(mag);
        sq_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
        if (n_held < 13'd8191) n_held++;
        if (lst || n_held >= CNT_W'(BUFFER_FRAMES)) close_buffer();
      end else begin
        if (peak == '0) begin
          rep.level = '0;
        end else begin
          quot = {smooth, 16'h0} / {16'h0, peak};
          rep.level = (quot > 48'hFFFF) ? 16'hFFFF : quot[15:0];
        end
        rep.trigger = 1'b0;
        if (en && !tch) begin
          peak = peak - (peak >> shift);
          rep.trigger = (rep.level > thresh);
        end
        rep.smooth_hi = smooth[31:16];
        due_reports = {due_reports, rep};
      end
    endfunction

    function void match_report(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        flag($sformatf("report with nothing due: level %0d trigger %0b smoothed %0d",
                       got.level, got.trigger, got.smooth_hi));
        return;
      end
      want = due_reports.pop_front();
      if (got !== want)
        flag($sformatf("level exp %0d got %0d, trigger exp %0b got %0b, smoothed exp %0d got %0d",
                       want.level, got.level, want.trigger, got.trigger,
                       want.smooth_hi, got.smooth_hi));
    endfunction
  endclass

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Block ports; the inputs are known from time zero
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // sample[15:0], touched[16], pad
  logic                   in_tuser   = 1'b0; // op
  logic                   in_tlast   = 1'b0; // last_of_buffer
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // level[15:0], trigger[16], smoothed_out[32:17]
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  rms_level_meter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  meter_tracker sb;
  int cycle_count = 0;
  int burst_left  = 0;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Monitors: sample at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.take_word(in_tuser, in_tdata[15:0], in_tlast, in_tdata[16]);
    if (rst_n && cfg_valid && cfg_ready)
      sb.set_reg(cfg_addr, cfg_wdata);
  end

  always @(posedge clk) begin : result_monitor
    report_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.level     = out_tdata[15:0];
      seen.trigger   = out_tdata[16];
      seen.smooth_hi = out_tdata[32:17];
      sb.match_report(seen);
    end
  end

  // Receiver back-pressure: modes of random length -- always ready, sparse ready,
  // on/off stretches of random length, and ready following the low bit of the cycle counter.
  int ready_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(200, 900);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) == 0);
      2: begin
        if (hold_left == 0) begin
          out_tready <= ~out_tready;
          hold_left  <= $urandom_range(1, 200);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
      default: out_tready <= cycle_count[0];
    endcase
  end

  // Send one input word. The sender runs in bursts; between bursts tvalid drops
  // for a random gap, or not at all. tvalid stays high across back-to-back words.
  task automatic send_word(input logic op, input logic [15:0] smp, input logic lst,
                           input logic tch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 24));
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                               : int'($urandom_range(1, 32));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= lst;
    in_tdata  <= {7'b0, tch, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // All four registers in one go; valid drops only after the last word
  task automatic program_regs(input logic en, input logic [15:0] w, input logic [4:0] sh,
                              input logic [15:0] tl);
    cfg_write(REG_ENABLE, {15'b0, en});
    cfg_write(REG_SMOOTH_WEIGHT, w);
    cfg_write(REG_DECAY_SHIFT, {11'b0, sh});
    cfg_write(REG_TRIGGER_LEVEL, tl);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every due report arrive, then let the back end finish any
  // buffer it is still closing (those give no report to wait on).
  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (sb.due_reports.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_reports.size() != 0) begin
      sb.flag($sformatf("%0d report(s) never arrived", sb.due_reports.size()));
      sb.due_reports.delete();
    end
  endtask

  // Mix of amplitudes: full scale random, quiet, extremes, mid range
  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom);
    if (r < 8) return 16'(int'($urandom_range(0, 510)) - 255);
    if (r == 8) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'(($urandom_range(0, 1) != 0) ? int'($urandom_range(1024, 8191))
                                           : -int'($urandom_range(1024, 8191)));
  endfunction

  // Mostly proper buffers followed by ticks; the rest raw noise. Buffer samples count
  // towards n only while audio is enabled.
  task automatic run_random(input int n, input logic en);
    int  done;
    int  r;
    int  len;
    int  ticks;
    logic lst;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 78) begin
        r = $urandom_range(0, 99);
        len = (r < 85) ? int'($urandom_range(1, 12))
            : (r < 96) ? int'($urandom_range(13, 64)) : int'($urandom_range(250, 300));
        for (int i = 0; i < len; i++) begin
          // long runs hit the full-buffer close at 256 words
          lst = (i == len - 1) && (len < BUFFER_FRAMES || $urandom_range(0, 1) != 0);
          send_word(OP_SAMPLE, pick_sample(), lst, 1'($urandom_range(0, 1)));
          if (en) done++;
        end
        ticks = $urandom_range(1, 3);
        for (int i = 0; i < ticks; i++) begin
          send_word(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 4) == 0);
          done++;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_word(1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          done++;
        end
      end
    end
    // leave a partial buffer behind now and then, carried into the next setting
    len = $urandom_range(0, 3);
    for (int i = 0; i < len; i++)
      send_word(OP_SAMPLE, pick_sample(), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic        en;
    logic [15:0] w;
    logic [4:0]  sh;
    logic [15:0] tl;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset register values
    send_word(OP_TICK,   16'h0000, 1'b0, 1'b0);  // zero peak gives level 0
    send_word(OP_SAMPLE, 16'h7FFF, 1'b0, 1'b1);  // positive full scale, touch ignored
    send_word(OP_SAMPLE, 16'h8000, 1'b1, 1'b0);  // negative full scale closes buffer
    send_word(OP_TICK,   16'h0000, 1'b0, 1'b1);  // touched: no decay, no trigger
    send_word(OP_TICK,   16'hFFFF, 1'b1, 1'b0);
    send_word(OP_SAMPLE, 16'h8000, 1'b0, 1'b0);  // mean square of 1.0: RMS saturates
    send_word(OP_SAMPLE, 16'h8000, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 16'h8000, 1'b1, 1'b0);
    send_word(OP_TICK,   16'h0000, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 16'h0000, 1'b1, 1'b0);  // silent single-word buffer
    send_word(OP_SAMPLE, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_SAMPLE, 16'h0001, 1'b1, 1'b0);
    send_word(OP_TICK,   16'h0000, 1'b0, 1'b0);
    send_word(OP_TICK,   16'h0000, 1'b0, 1'b1);
    send_word(OP_SAMPLE, 16'h7FFF, 1'b1, 1'b0);
    send_word(OP_TICK,   16'h0000, 1'b0, 1'b0);
    settle();

    // Register settings: extremes first, then random ones
    for (int p = 0; p < 8; p++) begin
      w  = 16'($urandom);
      tl = 16'($urandom);
      sh = 5'($urandom_range(0, 31));
      en = ($urandom_range(0, 4) != 0);
      case (p)
        0: begin en = 1'b1; w = 16'hFFFF; sh = 5'd1;  tl = 16'h0000; end
        1: begin en = 1'b1; w = 16'h0000; sh = 5'd31; tl = 16'hFFFF; end  // trigger never fires
        2: begin en = 1'b0; sh = 5'd0; end                                // audio off
        3: begin en = 1'b1; sh = 5'd0; end                                // decay clears peak
        4: en = 1'b1;
        default: ;
      endcase
      program_regs(en, w, sh, tl);
      run_random(en ? 250 : 60, en);
      settle();
    end

    if (sb.faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
